[hdl/fqa_pkg.sv]
package fqa_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned DivBits  = DataW + FracBits;
  localparam int unsigned ProdW    = 2 * DataW;

  typedef enum logic [3:0] {
    OpAdd    = 4'd0,
    OpSub    = 4'd1,
    OpMul    = 4'd2,
    OpDiv    = 4'd3,
    OpMin    = 4'd4,
    OpMax    = 4'd5,
    OpInc    = 4'd6,
    OpFromInt = 4'd7,
    OpToInt  = 4'd8
  } op_e;

  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};

  // Sideband that rides next to the divider.
  typedef struct packed {
    logic             is_div;
    logic             neg;
    logic [DataW-1:0] res;
    logic             ovf;
    logic             dz;
    logic             lt;
    logic             eq;
    logic             gt;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic                    is_mul;
    logic signed [ProdW-1:0] prod;
  } front_t;

endpackage

[hdl/fqa_div.sv]
module fqa_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [fqa_pkg::DivBits-1:0]    dividend_i,
  input  logic [fqa_pkg::DataW-1:0]      divisor_i,
  output logic [fqa_pkg::DivBits-1:0]    quotient_o
);

  localparam int unsigned N = fqa_pkg::DivBits;
  localparam int unsigned W = fqa_pkg::DataW;

  logic [W-1:0] rem_q [N];
  logic [N-1:0] dvd_q [N];
  logic [W-1:0] dsr_q [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [W-1:0] rem_in;
    logic [N-1:0] dvd_in;
    logic [W-1:0] dsr_in;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         take;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend_i;
      assign dsr_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dvd_in = dvd_q[j-1];
      assign dsr_in = dsr_q[j-1];
    end

    // Restoring step: bring down one dividend bit, subtract when it fits.
    assign trial = {rem_in, dvd_in[N-1]};
    assign diff  = trial - {1'b0, dsr_in};
    assign take  = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? diff[W-1:0] : trial[W-1:0];
        dvd_q[j] <= {dvd_in[N-2:0], take};
        dsr_q[j] <= dsr_in;
      end
    end
  end

  assign quotient_o = dvd_q[N-1];

endmodule

[hdl/fixed_point_q24_8_alu.sv]
// Channel | Handshake              | Payload
// in      | in_valid_i/in_ready_o  | opcode_i, operand_a_i, operand_b_i
// out     | out_valid_o/out_ready_i| result_value_o, a_less_o, a_equal_o,
//         |                        | a_greater_o, divide_by_zero_o, overflow_o
//
// One beat enters per cycle while the output is not stalled; a result passes
// stage A and the sideband delay line, beside the radix-2 divider that spends
// one stage per quotient bit (40 bits), and then the output register.
// Reset clears the valid bits only; data registers hold whatever they had.
// A stall at the output freezes every stage at once; in_ready_o follows the
// output register, so no beat is lost or repeated.
module fixed_point_q24_8_alu (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [3:0]                       opcode_i,
  input  logic signed [fqa_pkg::DataW-1:0] operand_a_i,
  input  logic signed [fqa_pkg::DataW-1:0] operand_b_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [fqa_pkg::DataW-1:0] result_value_o,
  output logic                             a_less_o,
  output logic                             a_equal_o,
  output logic                             a_greater_o,
  output logic                             divide_by_zero_o,
  output logic                             overflow_o
);

  localparam int unsigned W  = fqa_pkg::DataW;
  localparam int unsigned F  = fqa_pkg::FracBits;
  localparam int unsigned N  = fqa_pkg::DivBits;
  localparam int unsigned PW = fqa_pkg::ProdW;

  logic en;
  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage A: decode, simple ops, multiply ----------------
  fqa_pkg::front_t a_d, a_q;
  logic            a_v_q;

  logic signed [W:0]   sum_w, dif_w, inc_w;
  logic signed [W+F-1:0] fi_w;
  logic                lt, eq, gt;

  always_comb begin
    sum_w = {operand_a_i[W-1], operand_a_i} + {operand_b_i[W-1], operand_b_i};
    dif_w = {operand_a_i[W-1], operand_a_i} - {operand_b_i[W-1], operand_b_i};
    inc_w = {operand_a_i[W-1], operand_a_i} + (W+1)'(1);
    fi_w  = {operand_a_i, {F{1'b0}}};
    lt    = operand_a_i < operand_b_i;
    eq    = operand_a_i == operand_b_i;
    gt    = operand_a_i > operand_b_i;

    a_d             = '0;
    a_d.side.lt     = lt;
    a_d.side.eq     = eq;
    a_d.side.gt     = gt;
    a_d.side.neg    = operand_a_i[W-1] ^ operand_b_i[W-1];
    // Full 32 x 32 signed product.
    a_d.prod        = PW'(operand_a_i * operand_b_i);

    unique case (opcode_i)
      fqa_pkg::OpAdd: begin
        a_d.side.ovf = sum_w[W] ^ sum_w[W-1];
        a_d.side.res = a_d.side.ovf ? (sum_w[W] ? fqa_pkg::MinVal : fqa_pkg::MaxVal)
                                    : sum_w[W-1:0];
      end
      fqa_pkg::OpSub: begin
        a_d.side.ovf = dif_w[W] ^ dif_w[W-1];
        a_d.side.res = a_d.side.ovf ? (dif_w[W] ? fqa_pkg::MinVal : fqa_pkg::MaxVal)
                                    : dif_w[W-1:0];
      end
      fqa_pkg::OpMul: a_d.is_mul = 1'b1;
      fqa_pkg::OpDiv: begin
        a_d.side.is_div = (operand_b_i != '0);
        a_d.side.dz     = (operand_b_i == '0);
      end
      fqa_pkg::OpMin: a_d.side.res = lt ? operand_a_i : operand_b_i;
      fqa_pkg::OpMax: a_d.side.res = gt ? operand_a_i : operand_b_i;
      fqa_pkg::OpInc: begin
        a_d.side.ovf = inc_w[W] ^ inc_w[W-1];
        a_d.side.res = a_d.side.ovf ? fqa_pkg::MaxVal : inc_w[W-1:0];
      end
      fqa_pkg::OpFromInt: begin
        // Overflow when the bits shifted out differ from the new sign.
        a_d.side.ovf = (fi_w[W+F-1:W-1] != {(F+1){fi_w[W+F-1]}});
        a_d.side.res = a_d.side.ovf ? (fi_w[W+F-1] ? fqa_pkg::MinVal : fqa_pkg::MaxVal)
                                    : fi_w[W-1:0];
      end
      fqa_pkg::OpToInt: a_d.side.res = W'(operand_a_i >>> F);
      default: a_d.side.res = '0;
    endcase
  end

  logic [W-1:0] mag_a, mag_b;
  assign mag_a = operand_a_i[W-1] ? W'(-operand_a_i) : operand_a_i;
  assign mag_b = operand_b_i[W-1] ? W'(-operand_b_i) : operand_b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic [N-1:0] quotient;

  fqa_div u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({mag_a, {F{1'b0}}}),
    .divisor_i  (mag_b),
    .quotient_o (quotient)
  );

  // Divider input is taken at the same edge as stage A; with stage A in front, the
  // sideband delay line runs N-1 stages to line up with the quotient.
  // ---------------- multiply finish and sideband delay ----------------
  fqa_pkg::side_t        sb0_d;
  logic signed [PW-1:0]  p_adj;
  logic signed [PW-1:0]  p_sh;

  always_comb begin
    // Truncate toward zero: bias negative products before the shift.
    p_adj = a_q.prod + (a_q.prod[PW-1] ? PW'((1 << F) - 1) : PW'(0));
    p_sh  = p_adj >>> F;
    sb0_d = a_q.side;
    if (a_q.is_mul) begin
      if (p_sh > PW'(fqa_pkg::MaxVal)) begin
        sb0_d.ovf = 1'b1;
        sb0_d.res = fqa_pkg::MaxVal;
      end else if (p_sh < PW'(fqa_pkg::MinVal)) begin
        sb0_d.ovf = 1'b1;
        sb0_d.res = fqa_pkg::MinVal;
      end else begin
        sb0_d.res = p_sh[W-1:0];
      end
    end
  end

  fqa_pkg::side_t sb_q [N-1];
  logic [N-2:0]   sb_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= '0;
    end else if (en) begin
      sb_v_q <= {sb_v_q[N-3:0], a_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb0_d;
      for (int k = 1; k < N - 1; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // ---------------- divide finish and output register ----------------
  fqa_pkg::side_t sl;
  fqa_pkg::side_t o_d, o_q;
  logic           o_v_q;

  assign sl = sb_q[N-2];

  always_comb begin
    o_d = sl;
    if (sl.is_div) begin
      if (sl.neg) begin
        // Magnitude up to 2^(W-1) still fits once negated.
        if (quotient > N'({1'b1, {(W-1){1'b0}}})) begin
          o_d.ovf = 1'b1;
          o_d.res = fqa_pkg::MinVal;
        end else begin
          o_d.res = W'(-quotient);
        end
      end else if (quotient > N'(fqa_pkg::MaxVal)) begin
        o_d.ovf = 1'b1;
        o_d.res = fqa_pkg::MaxVal;
      end else begin
        o_d.res = quotient[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en) begin
      o_v_q <= sb_v_q[N-2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_q <= o_d;
    end
  end

  assign out_valid_o      = o_v_q;
  assign result_value_o   = o_q.res;
  assign a_less_o         = o_q.lt;
  assign a_equal_o        = o_q.eq;
  assign a_greater_o      = o_q.gt;
  assign divide_by_zero_o = o_q.dz;
  assign overflow_o       = o_q.ovf;

endmodule

[hdl/fqa_checker.sv]
module fqa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [fqa_pkg::DataW-1:0] result_value_o,
  input logic                             a_less_o,
  input logic                             a_equal_o,
  input logic                             a_greater_o,
  input logic                             divide_by_zero_o,
  input logic                             overflow_o
);

  // Exactly one compare flag per beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({a_less_o, a_equal_o, a_greater_o}))
    else $error("compare flags not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_by_zero_o) |-> (result_value_o == '0 && !overflow_o))
    else $error("divide by zero beat not zeroed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (result_value_o == fqa_pkg::MaxVal || result_value_o == fqa_pkg::MinVal))
    else $error("overflow without saturated value");

  // A stalled output freezes the pipe, so the input must stall too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken during output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_value_o)))
    else $error("stalled beat changed");

endmodule

bind fixed_point_q24_8_alu fqa_checker u_fqa_checker (.*);

[tb/sv/fixed_point_q24_8_alu_checker.sv]
module fixed_point_q24_8_alu_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [3:0]                       opcode_i,
  input  logic signed [fqa_pkg::DataW-1:0] operand_a_i,
  input  logic signed [fqa_pkg::DataW-1:0] operand_b_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [fqa_pkg::DataW-1:0] result_value_i,
  input  logic                             a_less_i,
  input  logic                             a_equal_i,
  input  logic                             a_greater_i,
  input  logic                             divide_by_zero_i,
  input  logic                             overflow_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               dz;
    logic               ovf;
  } alu_res_t;

  alu_res_t alu_results_q[$];
  int       fails = 0;
  int       pending_q = 0;

  // clamp a wide exact value to 32 bits, raising the overflow flag
  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v,
                                                 inout logic ovf);
    if (v > 80'sd2147483647) begin
      ovf = 1'b1;
      return fqa_pkg::MaxVal;
    end
    if (v < -80'sd2147483648) begin
      ovf = 1'b1;
      return fqa_pkg::MinVal;
    end
    return v[31:0];
  endfunction

  function automatic alu_res_t compute_alu(input logic [3:0] op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_res_t           r;
    logic signed [79:0] wa;
    logic signed [79:0] wb;
    logic               ovf;
    wa = a;
    wb = b;
    ovf = 1'b0;
    r = '0;
    case (op)
      fqa_pkg::OpAdd:     r.value = clamp32(wa + wb, ovf);
      fqa_pkg::OpSub:     r.value = clamp32(wa - wb, ovf);
      fqa_pkg::OpMul:     r.value = clamp32((wa * wb) / 80'sd256, ovf);  // toward zero
      fqa_pkg::OpDiv: begin
        if (b == 0) r.dz = 1'b1;
        else r.value = clamp32((wa * 80'sd256) / wb, ovf);
      end
      fqa_pkg::OpMin:     r.value = (a < b) ? a : b;
      fqa_pkg::OpMax:     r.value = (a > b) ? a : b;
      fqa_pkg::OpInc:     r.value = clamp32(wa + 80'sd1, ovf);
      fqa_pkg::OpFromInt: r.value = clamp32(wa * 80'sd256, ovf);
      fqa_pkg::OpToInt:   r.value = a >>> fqa_pkg::FracBits;  // floor
      default:            r.value = '0;
    endcase
    r.ovf = ovf;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    return r;
  endfunction

  assign pending_o    = pending_q;
  assign fail_count_o = fails;

  always @(posedge clk_i) begin
    alu_res_t want;
    alu_res_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        alu_results_q.push_back(compute_alu(opcode_i, operand_a_i, operand_b_i));
      if (out_valid_i && out_ready_i) begin
        got = '{result_value_i, a_less_i, a_equal_i, a_greater_i,
                divide_by_zero_i, overflow_i};
        if (alu_results_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          fails <= fails + 1;
        end else begin
          want = alu_results_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected val=%h lt%b eq%b gt%b dz%b ov%b",
                     $time, want.value, want.lt, want.eq, want.gt, want.dz, want.ovf);
            $display("%0t:          actual   val=%h lt%b eq%b gt%b dz%b ov%b",
                     $time, got.value, got.lt, got.eq, got.gt, got.dz, got.ovf);
            fails <= fails + 1;
          end
        end
      end
    end
    pending_q <= alu_results_q.size();
  end
endmodule

[tb/sv/fixed_point_q24_8_alu_tb.sv]
module fixed_point_q24_8_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 450;
  localparam int CycleLimit = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         opcode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] result_value;
  logic               a_less;
  logic               a_equal;
  logic               a_greater;
  logic               divide_by_zero;
  logic               overflow;
  int                 fail_count;
  int                 pending;
  int                 cycle_count;
  bit                 stim_done;

  fixed_point_q24_8_alu u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .operand_a_i     (operand_a),
    .operand_b_i     (operand_b),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_value_o  (result_value),
    .a_less_o        (a_less),
    .a_equal_o       (a_equal),
    .a_greater_o     (a_greater),
    .divide_by_zero_o(divide_by_zero),
    .overflow_o      (overflow)
  );

  fixed_point_q24_8_alu_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .operand_a_i     (operand_a),
    .operand_b_i     (operand_b),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .result_value_i  (result_value),
    .a_less_i        (a_less),
    .a_equal_i       (a_equal),
    .a_greater_i     (a_greater),
    .divide_by_zero_i(divide_by_zero),
    .overflow_i      (overflow),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest correct run is far below this.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Pick an operand that often lands on a boundary or a small value.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 8) - 4;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      4: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $urandom();
    endcase
  endfunction

  // Send one beat: wait a random gap, hold valid until accepted.
  task automatic send_beat(input logic [3:0] op, input logic [31:0] a,
                           input logic [31:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain side: stall the output for a random count per beat.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    fqa_pkg::op_e ops[9];
    stim_done = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    opcode    = '0;
    operand_a = '0;
    operand_b = '0;
    ops = '{fqa_pkg::OpAdd, fqa_pkg::OpSub, fqa_pkg::OpMul, fqa_pkg::OpDiv,
            fqa_pkg::OpMin, fqa_pkg::OpMax, fqa_pkg::OpInc, fqa_pkg::OpFromInt,
            fqa_pkg::OpToInt};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every opcode at the range ends, saturation and divide by zero.
    foreach (ops[i]) send_beat(ops[i], fqa_pkg::MaxVal, fqa_pkg::MinVal);
    send_beat(fqa_pkg::OpAdd, fqa_pkg::MaxVal, fqa_pkg::MaxVal);
    send_beat(fqa_pkg::OpSub, fqa_pkg::MinVal, 32'sd1);
    send_beat(fqa_pkg::OpMul, fqa_pkg::MinVal, fqa_pkg::MinVal);
    send_beat(fqa_pkg::OpMul, -32'sd300, 32'sd1);
    send_beat(fqa_pkg::OpDiv, 32'sd5, 32'sd0);
    send_beat(fqa_pkg::OpDiv, fqa_pkg::MinVal, -32'sd1);
    send_beat(fqa_pkg::OpDiv, -32'sd7, 32'sd512);
    send_beat(fqa_pkg::OpInc, fqa_pkg::MaxVal, 32'sd0);
    send_beat(fqa_pkg::OpFromInt, 32'sh0080_0000, 32'sd0);
    send_beat(fqa_pkg::OpToInt, -32'sd1, -32'sd1);
    send_beat(fqa_pkg::OpMin, 32'sd3, 32'sd3);
    send_beat(4'd9, 32'sd1, 32'sd2);
    send_beat(4'd15, -32'sd1, 32'sd2);

    // Random: mostly legal opcodes, a few unused ones.
    for (int n = 0; n < NumRandom; n++) begin
      logic [3:0] op;
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
      send_beat(op, pick_operand(), ($urandom_range(0, 19) == 0) ? 32'd0
                                                                 : pick_operand());
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  // Verdict: wait for the queue to empty, then for the pipeline latency.
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
